/* rtl/bstk_pkg.sv */
package bstk_pkg;

   localparam int SCORE_W = 32;
   localparam int TAG_W = 16;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int CAP_W = 5;
   localparam int POS_W = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
      logic [INDEX_W-1:0]        index;
   } bstk_req_type;

   typedef struct packed {
      logic                      accepted;
      logic [POS_W-1:0]          position;
      logic [COUNT_W-1:0]        count;
      logic                      read_valid;
      logic signed [SCORE_W-1:0] read_score;
      logic [TAG_W-1:0]          read_tag;
   } bstk_rsp_type;

   typedef struct packed {
      logic load;
      logic rd_index;
      logic rd_last;
      logic grow;
      logic rd_above;
      logic shift;
      logic place;
      logic set_reject;
      logic set_read;
   } bstk_cmd_type;

   typedef struct packed {
      logic is_read;
      logic full;
      logic count_zero;
      logic slot_zero;
      logic slot_one;
      logic beats;
   } bstk_status_type;

endpackage

/* rtl/bstk_if.sv */
interface bstk_req_if;
   import bstk_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic signed [SCORE_W-1:0] score;
   logic [TAG_W-1:0]          tag;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, cmd, score, tag, index, input ready);
   modport sink (input valid, cmd, score, tag, index, output ready);
endinterface

interface bstk_rsp_if;
   import bstk_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      accepted;
   logic [POS_W-1:0]          position;
   logic [COUNT_W-1:0]        count;
   logic                      read_valid;
   logic signed [SCORE_W-1:0] read_score;
   logic [TAG_W-1:0]          read_tag;

   modport source (output valid, accepted, position, count, read_valid, read_score, read_tag,
                   input ready);
   modport sink (input valid, accepted, position, count, read_valid, read_score, read_tag,
                 output ready);
endinterface

interface bstk_csr_if;
   import bstk_pkg::*;

   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink (input valid, capacity, output ready);
endinterface

/* rtl/bstk_ctrl.sv */
module bstk_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  bstk_pkg::bstk_status_type status,
   output bstk_pkg::bstk_cmd_type    cmd
);
   import bstk_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_CHECK  = 7'b0000100,
      S_SHIFT  = 7'b0001000,
      S_PLACE  = 7'b0010000,
      S_READ   = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_read) begin
               cmd.rd_index = 1'b1;
               state_in     = S_READ;
            end else if (status.full) begin
               cmd.rd_last = 1'b1;
               state_in    = S_CHECK;
            end else begin
               cmd.grow = 1'b1;
               state_in = status.count_zero ? S_PLACE : S_SHIFT;
            end
         end
         S_CHECK: begin
            if (!status.beats) begin
               cmd.set_reject = 1'b1;
               state_in       = S_RESP;
            end else if (status.slot_zero) begin
               state_in = S_PLACE;
            end else begin
               cmd.rd_above = 1'b1;
               state_in     = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (status.beats) begin
               cmd.shift = 1'b1;
               state_in  = status.slot_one ? S_PLACE : S_SHIFT;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_RESP;
         end
         S_READ: begin
            cmd.set_read = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/bstk_dp.sv */
module bstk_dp #(
   parameter int MAX_ENTRIES = 16,
   parameter int TAG_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bstk_pkg::bstk_cmd_type           cmd,
   output bstk_pkg::bstk_status_type        status,
   input  bstk_pkg::bstk_req_type           req,
   output bstk_pkg::bstk_rsp_type           rsp,
   input  logic                             csr_write,
   input  logic [bstk_pkg::CAP_W-1:0]       csr_capacity
);
   import bstk_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int ENT_W = SCORE_W + TAG_BITS;

   logic [ENT_W-1:0]         mem [MAX_ENTRIES];

   bstk_req_type             req_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [IDX_W-1:0]         slot_ff;
   logic [IDX_W-1:0]         slot_in;
   logic [ENT_W-1:0]         rdata_ff;
   logic                     hit_ff;
   logic                     acc_ff;
   logic [POS_W-1:0]         pos_ff;
   logic                     rvalid_ff;
   logic signed [SCORE_W-1:0] rscore_ff;
   logic [TAG_W-1:0]         rtag_ff;

   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         live_wide;
   logic [CNT_W-1:0]         live_cap;
   logic [IDX_W-1:0]         live_last;
   logic [CMP_W-1:0]         idx_cmp;
   logic                     hit;
   logic [IDX_W+INDEX_W-1:0] idx_wide;
   logic [IDX_W+INDEX_W-1:0] slot_wide;
   logic [TAG_BITS+TAG_W-1:0] tag_in_wide;
   logic [TAG_BITS+TAG_W-1:0] tag_out_wide;
   logic [CNT_W+COUNT_W-1:0] count_wide;
   logic signed [SCORE_W-1:0] rd_score;
   logic [TAG_BITS-1:0]      rd_tag;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [ENT_W-1:0]         wr_data;

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         live_wide = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         live_wide = CMP_W'(MAX_ENTRIES);
      end else begin
         live_wide = cap_ext;
      end
   end

   assign live_cap     = CNT_W'(live_wide);
   assign live_last    = IDX_W'(live_cap - CNT_W'(1));
   assign idx_cmp      = CMP_W'(req_ff.index);
   assign hit          = (idx_cmp < CMP_W'(count_ff)) && (idx_cmp < CMP_W'(MAX_ENTRIES));
   assign idx_wide     = {{IDX_W{1'b0}}, req_ff.index};
   assign slot_wide    = {{INDEX_W{1'b0}}, slot_ff};
   assign tag_in_wide  = {{TAG_BITS{1'b0}}, req_ff.tag};
   assign count_wide   = {{COUNT_W{1'b0}}, count_ff};
   assign rd_score     = rdata_ff[ENT_W-1 -: SCORE_W];
   assign rd_tag       = rdata_ff[TAG_BITS-1:0];
   assign tag_out_wide = {{TAG_W{1'b0}}, rd_tag};

   assign status.is_read    = (req_ff.cmd == CMD_READ);
   assign status.full       = (count_ff >= live_cap);
   assign status.count_zero = (count_ff == '0);
   assign status.slot_zero  = (slot_ff == '0);
   assign status.slot_one   = (slot_ff == IDX_W'(1));
   assign status.beats      = (req_ff.score > rd_score);

   // read address select
   always_comb begin
      rd_en   = cmd.rd_index | cmd.rd_last | cmd.grow | cmd.rd_above | cmd.shift;
      rd_addr = slot_ff - IDX_W'(1);
      if (cmd.rd_index) begin
         rd_addr = idx_wide[IDX_W-1:0];
      end else if (cmd.rd_last) begin
         rd_addr = live_last;
      end else if (cmd.grow) begin
         rd_addr = IDX_W'(count_ff - CNT_W'(1));
      end else if (cmd.shift) begin
         rd_addr = slot_ff - IDX_W'(2);
      end
   end

   assign wr_en   = cmd.shift | cmd.place;
   assign wr_data = cmd.shift ? rdata_ff : {req_ff.score, tag_in_wide[TAG_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[slot_ff] <= wr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (csr_write) begin
         count_in = '0;
      end else if (cmd.grow) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (cmd.grow) begin
         slot_in = IDX_W'(count_ff);
      end else if (cmd.rd_last) begin
         slot_in = live_last;
      end else if (cmd.shift) begin
         slot_in = slot_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
      end else begin
         if (csr_write) begin
            cap_ff <= csr_capacity;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.load) begin
         req_ff <= req;
      end
      if (cmd.rd_index) begin
         hit_ff <= hit;
      end
      if (cmd.place) begin
         acc_ff    <= 1'b1;
         pos_ff    <= slot_wide[POS_W-1:0];
         rvalid_ff <= 1'b0;
         rscore_ff <= '0;
         rtag_ff   <= '0;
      end else if (cmd.set_reject) begin
         acc_ff    <= 1'b0;
         pos_ff    <= '0;
         rvalid_ff <= 1'b0;
         rscore_ff <= '0;
         rtag_ff   <= '0;
      end else if (cmd.set_read) begin
         acc_ff    <= 1'b0;
         pos_ff    <= '0;
         rvalid_ff <= hit_ff;
         rscore_ff <= hit_ff ? rd_score : '0;
         rtag_ff   <= hit_ff ? tag_out_wide[TAG_W-1:0] : '0;
      end
   end

   assign rsp.accepted   = acc_ff;
   assign rsp.position   = pos_ff;
   assign rsp.count      = count_wide[COUNT_W-1:0];
   assign rsp.read_valid = rvalid_ff;
   assign rsp.read_score = rscore_ff;
   assign rsp.read_tag   = rtag_ff;

endmodule

/* rtl/bounded_sorted_top_k_insert.sv */
// channel  | direction | payload                                             | transfer
// req_if   | in        | cmd, score, tag, index                              | valid & ready
// rsp_if   | out       | accepted, position, count, read_valid, read_score,  | valid & ready
//          |           | read_tag                                            |
// csr_if   | in        | capacity                                            | valid & ready
//
// one item at a time; a new request is taken only once the response to the last one has been
// taken; an accepted insert shifts down each kept entry scoring below it, then writes the new
// entry into the freed slot
// the entry store moves one entry per cycle during the shift
// reset is synchronous; it sets capacity to 10 and empties the table
// a stalled response holds the block until it is taken; csr_if is always ready

module bounded_sorted_top_k_insert #(
   parameter int MAX_ENTRIES = 16,
   parameter int TAG_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   bstk_req_if.sink  req_if,
   bstk_rsp_if.source rsp_if,
   bstk_csr_if.sink  csr_if
);
   import bstk_pkg::*;

   bstk_cmd_type    cmd;
   bstk_status_type status;
   bstk_req_type    req;
   bstk_rsp_type    rsp;
   logic            req_ready;
   logic            rsp_valid;

   assign req.cmd   = req_if.cmd;
   assign req.score = req_if.score;
   assign req.tag   = req_if.tag;
   assign req.index = req_if.index;

   assign csr_if.ready = 1'b1;

   bstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bstk_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .TAG_BITS    (TAG_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req          (req),
      .rsp          (rsp),
      .csr_write    (csr_if.valid),
      .csr_capacity (csr_if.capacity)
   );

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = rsp_valid;
   assign rsp_if.accepted   = rsp.accepted;
   assign rsp_if.position   = rsp.position;
   assign rsp_if.count      = rsp.count;
   assign rsp_if.read_valid = rsp.read_valid;
   assign rsp_if.read_score = rsp.read_score;
   assign rsp_if.read_tag   = rsp.read_tag;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("new request taken while an item is in flight");

   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.accepted) |-> (rsp_if.position < rsp_if.count))
      else $error("insert placed at or beyond the entry count");

   a_read_excludes_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.read_valid) |-> (!rsp_if.accepted && rsp_if.count != 0))
      else $error("valid read on an insert result or an empty table");
`endif

endmodule
